// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

// ----- rtl/kbt_pkg.sv -----
// Shared types and constants of the three-axis Kalman bias tracker.
`timescale 1ns / 1ps

package kbt_pkg;

    localparam int AXES          = 3;
    localparam int AXIS_W        = $clog2(AXES);
    localparam int SAMPLE_W      = 16;
    localparam int DATA_W        = 32;
    localparam int GAIN_BITS     = 16;
    localparam int FRAC_BITS_DEF = 16;
    localparam int ADDR_W        = 3;
    localparam int REG_IDX_W     = 1;

    localparam logic [DATA_W-1:0] DRIFT_VAR_RESET = 32'd66;

    localparam logic [REG_IDX_W-1:0] REG_DRIFT_VAR  = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_SAMPLE_VAR = 1'b1;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_x;
        logic signed [SAMPLE_W-1:0] sample_y;
        logic signed [SAMPLE_W-1:0] sample_z;
    } kbt_sample_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] bias_est_x;
        logic signed [DATA_W-1:0] bias_est_y;
        logic signed [DATA_W-1:0] bias_est_z;
    } kbt_bias_t;

    typedef struct packed {
        logic [DATA_W-1:0] drift_var;
        logic [DATA_W-1:0] sample_var;
    } kbt_cfg_t;

endpackage

// ----- rtl/kalman_bias_tracker_three_axis_core.sv -----
// Top level of the three-axis Kalman bias tracker.
`timescale 1ns / 1ps

// Tracks a random-walk bias on each of three sensor axes with a scalar Kalman
// filter per axis. Each accepted word carries one sample per axis; the axes are
// updated one after another by a single engine whose gain division yields one
// quotient bit per cycle (17 bits), with the gain products built MSB-first
// alongside it. No new sample word is taken while the axes are updated; a new
// word is taken once the result has moved to the output register; that move
// waits only while an older result is still held there. Noise registers are
// written over APB at byte addresses 0 (process) and 4 (measurement).

module kalman_bias_tracker_three_axis_core #(
    parameter int FRAC_BITS = kbt_pkg::FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         sample_valid,
    output logic                         sample_ready,
    input  kbt_pkg::kbt_sample_t         sample,
    output logic                         bias_valid,
    input  logic                         bias_ready,
    output kbt_pkg::kbt_bias_t           bias,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [kbt_pkg::ADDR_W-1:0]   paddr,
    input  logic [kbt_pkg::DATA_W-1:0]   pwdata,
    output logic [kbt_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);
    import kbt_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    localparam logic [DATA_W-1:0]  FIX_ONE   = DATA_W'(1) << FRAC_BITS;
    localparam logic [AXIS_W-1:0]  AXIS_LAST = AXIS_W'(AXES - 1);

    kbt_cfg_t cfg;

    logic [1:0]                 state_reg,     state_next;
    logic [AXIS_W-1:0]          axis_reg,      axis_next;
    logic                       start_reg,     start_next;
    logic                       out_valid_reg, out_valid_next;
    logic signed [SAMPLE_W-1:0] samp_reg     [AXES];
    logic signed [DATA_W-1:0]   bias_arr_reg [AXES];
    logic [DATA_W-1:0]          var_arr_reg  [AXES];
    kbt_bias_t                  out_reg;

    logic                       capture;
    logic                       write_axis;
    logic                       load_out;
    logic                       eng_done;
    logic signed [DATA_W-1:0]   eng_bias;
    logic [DATA_W-1:0]          eng_var;

    kbt_apb_regs #(
        .FRAC_BITS (FRAC_BITS)
    ) u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    kbt_axis_engine #(
        .FRAC_BITS (FRAC_BITS)
    ) u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start_reg),
        .variance (var_arr_reg[axis_reg]),
        .bias     (bias_arr_reg[axis_reg]),
        .sample   (samp_reg[axis_reg]),
        .cfg      (cfg),
        .done     (eng_done),
        .new_bias (eng_bias),
        .new_var  (eng_var)
    );

    assign sample_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        axis_next      = axis_reg;
        start_next     = 1'b0;
        out_valid_next = out_valid_reg;
        capture        = 1'b0;
        write_axis     = 1'b0;
        load_out       = 1'b0;
        if (out_valid_reg && bias_ready)
            out_valid_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample_valid)
                begin
                    capture    = 1'b1;
                    axis_next  = '0;
                    start_next = 1'b1;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (eng_done)
                begin
                    write_axis = 1'b1;
                    if (axis_reg == AXIS_LAST)
                        state_next = ST_EMIT;
                    else
                    begin
                        axis_next  = axis_reg + AXIS_W'(1);
                        start_next = 1'b1;
                    end
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || bias_ready)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            axis_reg      <= '0;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < AXES; i++)
            begin
                bias_arr_reg[i] <= '0;
                var_arr_reg[i]  <= FIX_ONE;
            end
        end
        else
        begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
            if (write_axis)
            begin
                bias_arr_reg[axis_reg] <= eng_bias;
                var_arr_reg[axis_reg]  <= eng_var;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            samp_reg[0] <= sample.sample_x;
            samp_reg[1] <= sample.sample_y;
            samp_reg[2] <= sample.sample_z;
        end
        if (load_out)
        begin
            out_reg.bias_est_x <= bias_arr_reg[0];
            out_reg.bias_est_y <= bias_arr_reg[1];
            out_reg.bias_est_z <= bias_arr_reg[2];
        end
    end

    assign bias_valid = out_valid_reg;
    assign bias       = out_reg;

endmodule

// ----- rtl/kbt_apb_regs.sv -----
// APB configuration registers: process and measurement noise.
`timescale 1ns / 1ps

module kbt_apb_regs #(
    parameter int FRAC_BITS = kbt_pkg::FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [kbt_pkg::ADDR_W-1:0]   paddr,
    input  logic [kbt_pkg::DATA_W-1:0]   pwdata,
    output logic [kbt_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    output kbt_pkg::kbt_cfg_t            cfg
);
    import kbt_pkg::*;

    localparam logic [DATA_W-1:0] FIX_ONE = DATA_W'(1) << FRAC_BITS;

    logic [DATA_W-1:0]    pn_reg;
    logic [DATA_W-1:0]    pn_next;
    logic [DATA_W-1:0]    mn_reg;
    logic [DATA_W-1:0]    mn_next;
    logic [REG_IDX_W-1:0] idx;
    logic                 wr_en;

    assign idx    = paddr[ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_comb
    begin
        pn_next = pn_reg;
        mn_next = mn_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_DRIFT_VAR:  pn_next = pwdata;
                REG_SAMPLE_VAR: mn_next = pwdata;
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_DRIFT_VAR:  prdata = pn_reg;
            REG_SAMPLE_VAR: prdata = mn_reg;
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pn_reg <= DRIFT_VAR_RESET;
            mn_reg <= FIX_ONE;
        end
        else
        begin
            pn_reg <= pn_next;
            mn_reg <= mn_next;
        end
    end

    assign cfg = {pn_reg, mn_reg};

endmodule

// ----- rtl/kbt_axis_engine.sv -----
// One-axis update: bit-serial gain division with MSB-first shift-add products.
`timescale 1ns / 1ps

module kbt_axis_engine #(
    parameter int FRAC_BITS = kbt_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic        [kbt_pkg::DATA_W-1:0]   variance,
    input  logic signed [kbt_pkg::DATA_W-1:0]   bias,
    input  logic signed [kbt_pkg::SAMPLE_W-1:0] sample,
    input  kbt_pkg::kbt_cfg_t                   cfg,
    output logic                                done,
    output logic signed [kbt_pkg::DATA_W-1:0]   new_bias,
    output logic        [kbt_pkg::DATA_W-1:0]   new_var
);
    import kbt_pkg::*;

    localparam int MEAS_W  = SAMPLE_W + FRAC_BITS;
    localparam int INNOV_W = ((MEAS_W > DATA_W) ? MEAS_W : DATA_W) + 1;
    localparam int K_W     = GAIN_BITS + 1;
    localparam int ACC_W   = INNOV_W + K_W;
    localparam int DEN_W   = DATA_W + 1;
    localparam int TRIAL_W = DEN_W + 1;
    localparam int KP_W    = DATA_W + GAIN_BITS;
    localparam int DELTA_W = ACC_W - GAIN_BITS;
    localparam int SUM_W   = DELTA_W + 1;
    localparam int CNT_W   = 5;

    localparam logic [CNT_W-1:0] CNT_DEN       = 5'd0;
    localparam logic [CNT_W-1:0] CNT_FIRST_DIV = 5'd1;
    localparam logic [CNT_W-1:0] CNT_LAST_DIV  = 5'd17;
    localparam logic [CNT_W-1:0] CNT_LAST_ACC  = 5'd18;
    localparam logic [CNT_W-1:0] CNT_FIN       = 5'd19;

    localparam logic signed [DATA_W-1:0] BIAS_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] BIAS_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    logic                      run_reg,   run_next;
    logic [CNT_W-1:0]          cnt_reg,   cnt_next;
    logic                      done_reg,  done_next;
    logic [DATA_W-1:0]         p_reg;
    logic [DEN_W-1:0]          den_reg;
    logic                      dz_reg;
    logic [DEN_W-1:0]          rem_reg;
    logic                      qbit_reg;
    logic signed [INNOV_W-1:0] innov_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic [KP_W-1:0]           kp_reg;
    logic signed [DATA_W-1:0]  new_bias_reg;
    logic [DATA_W-1:0]         new_var_reg;

    logic [DEN_W-1:0]          p_sum;
    logic [DATA_W-1:0]         p_sat;
    logic signed [MEAS_W-1:0]  meas;
    logic signed [INNOV_W-1:0] innov_start;
    logic                      in_bit;
    logic [TRIAL_W-1:0]        trial;
    logic [TRIAL_W-1:0]        trial_sub;
    logic                      qbit;
    logic [DEN_W-1:0]          rem_step;
    logic signed [ACC_W-1:0]   acc_step;
    logic [KP_W-1:0]           kp_step;
    logic signed [DELTA_W-1:0] delta;
    logic signed [SUM_W-1:0]   bias_sum;
    logic [SUM_W-DATA_W:0]     sum_hi;
    logic signed [DATA_W-1:0]  bias_sat;
    logic [KP_W-1:0]           var_diff;
    logic                      div_step;
    logic                      acc_step_en;

    assign p_sum       = {1'b0, variance} + {1'b0, cfg.drift_var};
    assign p_sat       = p_sum[DATA_W] ? {DATA_W{1'b1}} : p_sum[DATA_W-1:0];
    assign meas        = $signed({sample, {FRAC_BITS{1'b0}}});
    assign innov_start = INNOV_W'(meas) - INNOV_W'(bias);

    assign in_bit    = (cnt_reg == CNT_FIRST_DIV) ? p_reg[0] : 1'b0;
    assign trial     = {rem_reg, in_bit};
    assign trial_sub = trial - {1'b0, den_reg};
    assign qbit      = !dz_reg && (trial >= {1'b0, den_reg});
    assign rem_step  = qbit ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];

    assign acc_step = (acc_reg <<< 1) + (qbit_reg ? ACC_W'(innov_reg) : '0);
    assign kp_step  = (kp_reg << 1) + (qbit_reg ? KP_W'(p_reg) : '0);

    assign delta    = acc_reg[ACC_W-1:GAIN_BITS];
    assign bias_sum = SUM_W'(delta) + SUM_W'(bias);
    assign sum_hi   = bias_sum[SUM_W-1:DATA_W-1];
    assign bias_sat = ((&sum_hi) || (~|sum_hi)) ? bias_sum[DATA_W-1:0]
                    : (bias_sum[SUM_W-1] ? BIAS_MIN : BIAS_MAX);
    assign var_diff = {p_reg, {GAIN_BITS{1'b0}}} - kp_reg;

    assign div_step    = run_reg && (cnt_reg >= CNT_FIRST_DIV) && (cnt_reg <= CNT_LAST_DIV);
    assign acc_step_en = run_reg && (cnt_reg >= CNT_FIRST_DIV) && (cnt_reg <= CNT_LAST_ACC);

    always_comb
    begin
        run_next  = run_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = CNT_DEN;
        end
        else if (run_reg)
        begin
            if (cnt_reg == CNT_FIN)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            p_reg     <= p_sat;
            innov_reg <= innov_start;
            acc_reg   <= '0;
            kp_reg    <= '0;
            qbit_reg  <= 1'b0;
        end
        else
        begin
            if (run_reg && (cnt_reg == CNT_DEN))
            begin
                den_reg <= {1'b0, p_reg} + {1'b0, cfg.sample_var};
                dz_reg  <= ~|({1'b0, p_reg} + {1'b0, cfg.sample_var});
                rem_reg <= DEN_W'(p_reg >> 1);
            end
            if (div_step)
            begin
                rem_reg  <= rem_step;
                qbit_reg <= qbit;
            end
            if (acc_step_en)
            begin
                acc_reg <= acc_step;
                kp_reg  <= kp_step;
            end
            if (run_reg && (cnt_reg == CNT_FIN))
            begin
                new_bias_reg <= bias_sat;
                new_var_reg  <= var_diff[KP_W-1:GAIN_BITS];
            end
        end
    end

    assign done     = done_reg;
    assign new_bias = new_bias_reg;
    assign new_var  = new_var_reg;

endmodule

// ----- rtl/kbt_checker.sv -----
// Port-level checker for the bias tracker, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module kbt_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               sample_valid,
    input logic               sample_ready,
    input logic               bias_valid,
    input logic               bias_ready,
    input kbt_pkg::kbt_bias_t bias
);
    `ASSERT_NEXT(a_valid_hold, clk, rst_n, bias_valid && !bias_ready, bias_valid)
    `ASSERT_NEXT(a_bias_stable, clk, rst_n, bias_valid && !bias_ready, $stable(bias))
    `ASSERT_NEXT(a_busy_after_word, clk, rst_n, sample_valid && sample_ready, !sample_ready)
    `ASSERT_IMPL(a_result_from_work, clk, rst_n, $rose(bias_valid), $past(!sample_ready))
endmodule

bind kalman_bias_tracker_three_axis_core kbt_checker u_kbt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .bias_valid   (bias_valid),
    .bias_ready   (bias_ready),
    .bias         (bias)
);

// ----- tb/kalman_bias_tracker_three_axis_core_test.sv -----
// Testbench for the three-axis Kalman bias tracker core, with a built-in predictor.
`timescale 1ns / 1ps

module kalman_bias_tracker_three_axis_core_test;
    import kbt_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic sample_valid = 1'b0;
    logic sample_ready;
    kbt_sample_t sample = '0;
    logic bias_valid;
    logic bias_ready = 1'b0;
    kbt_bias_t bias;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic pready;

    logic signed [DATA_W-1:0] bias_state [AXES];
    logic [DATA_W-1:0] variance_state [AXES];
    logic [DATA_W-1:0] drift_var_cfg = DRIFT_VAR_RESET;
    logic [DATA_W-1:0] sample_var_cfg = 32'd65536;
    kbt_bias_t expected_bias [$];
    kbt_bias_t bias_want;
    int mismatch_count = 0;
    bit gaps_on = 1'b1;
    bit stall_on = 1'b1;

    kalman_bias_tracker_three_axis_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .bias_valid   (bias_valid),
        .bias_ready   (bias_ready),
        .bias         (bias),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        #20_000_000;
        $display("[kalman_bias_tracker_three_axis_core] ERROR");
        $finish;
    end

    task automatic report(input string what, input logic [DATA_W-1:0] got,
                          input logic [DATA_W-1:0] want);
        $display("%0t %s: got %h, expected %h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // One scalar filter step for one axis; updates the tracked state.
    function automatic logic signed [DATA_W-1:0] update_axis(input int ax,
                                                             input logic signed [15:0] smp);
        logic [63:0] p;
        logic [63:0] den;
        logic [63:0] gain;
        logic [63:0] v;
        longint innov;
        longint delta;
        longint nb;
        p = 64'(variance_state[ax]) + 64'(drift_var_cfg);
        if (p > 64'hFFFF_FFFF)
            p = 64'hFFFF_FFFF;
        den = p + 64'(sample_var_cfg);
        gain = (den == 64'd0) ? 64'd0 : (p << GAIN_BITS) / den;
        innov = longint'(smp) * (longint'(1) << FRAC_BITS_DEF) - longint'(bias_state[ax]);
        delta = (longint'(gain) * innov) >>> GAIN_BITS;
        nb = longint'(bias_state[ax]) + delta;
        if (nb > longint'(32'sh7FFF_FFFF))
            nb = longint'(32'sh7FFF_FFFF);
        else if (nb < longint'(32'sh8000_0000))
            nb = longint'(32'sh8000_0000);
        bias_state[ax] = nb[31:0];
        v = (((64'd1 << GAIN_BITS) - gain) * p) >> GAIN_BITS;
        variance_state[ax] = v[31:0];
        return bias_state[ax];
    endfunction

    function automatic kbt_bias_t track_bias(input kbt_sample_t s);
        kbt_bias_t r;
        r.bias_est_x = update_axis(0, s.sample_x);
        r.bias_est_y = update_axis(1, s.sample_y);
        r.bias_est_z = update_axis(2, s.sample_z);
        return r;
    endfunction

    function automatic kbt_sample_t mk(input int x, input int y, input int z);
        kbt_sample_t s;
        s.sample_x = 16'(x);
        s.sample_y = 16'(y);
        s.sample_z = 16'(z);
        return s;
    endfunction

    // Mostly noisy readings around a slowly held level, some raw noise, some extremes.
    function automatic logic signed [15:0] pick_count(input int level);
        int r;
        int v;
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            v = level + int'($urandom_range(0, 64)) - 32;
            if (v > 32767)
                v = 32767;
            if (v < -32768)
                v = -32768;
            return 16'(v);
        end
        else if (r < 85)
            return 16'($urandom);
        case ($urandom_range(0, 3))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sh0000;
            default: return 16'shFFFF;
        endcase
    endfunction

    // Called and returns at a falling edge.
    task automatic send_sample(input kbt_sample_t s);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            sample_valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        sample_valid = 1'b1;
        sample = s;
        do @(posedge clk); while (!sample_ready);
        expected_bias.push_back(track_bias(s));
        @(negedge clk);
        sample_valid = 1'b0;
    endtask

    task automatic check_reg(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] want);
        logic [DATA_W-1:0] got;
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = {idx, 2'b00};
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        got = prdata;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        if (got !== want)
            report("register readback", got, want);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        if (idx == REG_DRIFT_VAR)
            drift_var_cfg = value;
        else
            sample_var_cfg = value;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        check_reg(idx, value);
    endtask

    task automatic drain();
        while (expected_bias.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic configure(input logic [DATA_W-1:0] pn, input logic [DATA_W-1:0] mn);
        drain();
        write_reg(REG_DRIFT_VAR, pn);
        write_reg(REG_SAMPLE_VAR, mn);
    endtask

    task automatic send_random(input int count);
        int level [AXES];
        for (int a = 0; a < AXES; a++)
            level[a] = int'($urandom_range(0, 65535)) - 32768;
        for (int n = 0; n < count; n++)
            send_sample(mk(pick_count(level[0]), pick_count(level[1]), pick_count(level[2])));
    endtask

    task automatic test_register_reset();
        check_reg(REG_DRIFT_VAR, DRIFT_VAR_RESET);
        check_reg(REG_SAMPLE_VAR, 32'd65536);
    endtask

    task automatic test_sample_extremes();
        send_sample(mk(0, 0, 0));
        send_sample(mk(32767, -32768, -1));
        send_sample(mk(-32768, 32767, 1));
        send_sample(mk(16'sh5555, 16'shAAAA, 0));
        send_sample(mk(16'shAAAA, 16'sh5555, 32767));
    endtask

    // Gain of exactly one: bias jumps to the sample, variance collapses to zero.
    task automatic test_zero_sample_var();
        configure(DRIFT_VAR_RESET, 32'd0);
        send_sample(mk(32767, -32768, 0));
        send_sample(mk(-32768, 32767, -1));
        send_sample(mk(100, -100, 1));
    endtask

    // p + R == 0 once the variance is zero: gain forced to zero, bias held.
    task automatic test_zero_denominator();
        configure(32'd0, 32'd0);
        send_sample(mk(1234, -1234, 32767));
        send_sample(mk(-32768, 32767, 0));
        send_sample(mk(5, 5, 5));
    endtask

    task automatic test_variance_saturation();
        configure(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_sample(mk(32767, -32768, 7));
        send_sample(mk(-32768, 32767, -7));
        configure(32'hFFFF_FFFF, 32'd1);
        send_sample(mk(-32768, 32767, 0));
        send_sample(mk(32767, -32768, -1));
        configure(32'd1, 32'hFFFF_FFFF);
        send_sample(mk(32767, 32767, 32767));
    endtask

    task automatic test_random_tracking();
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: configure(DRIFT_VAR_RESET, 32'd65536);
                1: configure(32'd0, 32'hFFFF_FFFF);
                2: configure(32'hFFFF_FFFF, 32'd0);
                3: configure(32'h0000_0100, 32'h0010_0000);
                default: configure($urandom >> $urandom_range(0, 31),
                                   $urandom >> $urandom_range(0, 31));
            endcase
            send_random(120);
        end
    endtask

    task automatic test_pause_until_drained();
        configure(32'h0000_1000, 32'h0002_0000);
        send_random(10);
        drain();
        send_random(10);
    endtask

    task automatic test_back_to_back();
        configure(32'h0000_0042, 32'h0000_8000);
        gaps_on = 1'b0;
        stall_on = 1'b0;
        send_random(60);
    endtask

    initial
    begin
        forever
        begin
            @(negedge clk);
            if (stall_on && $urandom_range(0, 5) == 0)
            begin
                bias_ready = 1'b0;
                repeat ($urandom_range(1, 4) - 1) @(negedge clk);
            end
            else
                bias_ready = 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && bias_valid && bias_ready)
        begin
            if (expected_bias.size() == 0)
                report("bias word with nothing pending", bias.bias_est_x, '0);
            else
            begin
                bias_want = expected_bias.pop_front();
                if (bias.bias_est_x !== bias_want.bias_est_x)
                    report("bias_est_x", bias.bias_est_x, bias_want.bias_est_x);
                if (bias.bias_est_y !== bias_want.bias_est_y)
                    report("bias_est_y", bias.bias_est_y, bias_want.bias_est_y);
                if (bias.bias_est_z !== bias_want.bias_est_z)
                    report("bias_est_z", bias.bias_est_z, bias_want.bias_est_z);
            end
        end
    end

    initial
    begin
        for (int a = 0; a < AXES; a++)
        begin
            bias_state[a] = '0;
            variance_state[a] = 32'd65536;
        end
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_register_reset();
        test_sample_extremes();
        test_zero_sample_var();
        test_zero_denominator();
        test_variance_saturation();
        test_random_tracking();
        test_pause_until_drained();
        test_back_to_back();
        drain();
        repeat (100) @(negedge clk);
        if (mismatch_count == 0)
            $display("[kalman_bias_tracker_three_axis_core] OK");
        else
            $display("[kalman_bias_tracker_three_axis_core] ERROR");
        $finish;
    end

endmodule
